// ===== src/ljpf_pkg.sv =====
// Shared constants and IEEE single helpers for the pair force accumulator.
// Used by the arithmetic units and the top level; depends on nothing.
`default_nettype none
package ljpf_pkg;

   localparam logic [1:0] CMD_WRITE_POS  = 2'd0;
   localparam logic [1:0] CMD_PAIR       = 2'd1;
   localparam logic [1:0] CMD_READ_FORCE = 2'd2;
   localparam logic [1:0] CMD_WRITE_COEF = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_ZERO  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   localparam logic [31:0] FP_TWELVE     = 32'h4140_0000;
   localparam logic [31:0] FP_SIX        = 32'h40C0_0000;
   localparam logic [31:0] FP_DEFAULT_NAN = 32'hFFC0_0000;
   localparam logic [31:0] FP_QUIET_BIT  = 32'h0040_0000;

   typedef logic [31:0] fp_type;

   function automatic logic fp_is_nan(input fp_type v);
      fp_is_nan = (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
   endfunction

   function automatic logic fp_is_inf(input fp_type v);
      fp_is_inf = (v[30:23] == 8'hFF) && (v[22:0] == 23'd0);
   endfunction

   // leading zero count of a left-aligned 48-bit word (48 when all zero)
   function automatic logic [5:0] fp_lzc48(input logic [47:0] v);
      logic [5:0] n;
      n = 6'd48;
      for (int i = 0; i < 48; i++) begin
         if (v[i]) n = 6'(47 - i);
      end
      fp_lzc48 = n;
   endfunction

   // right shift keeping every lost bit in bit 0
   function automatic logic [26:0] fp_shr_sticky(input logic [26:0] v, input logic [7:0] n);
      logic [4:0]  s;
      logic [26:0] r;
      logic        lost;
      s = (n > 8'd27) ? 5'd27 : n[4:0];
      r = v >> s;
      lost = |(v & ((27'd1 << s) - 27'd1));
      fp_shr_sticky = {r[26:1], r[0] | lost};
   endfunction

   // mant[26] is the leading one of 1.x * 2^(be-127); bit 2 guard, bits 1:0 sticky
   function automatic fp_type fp_round(input logic sign, input logic signed [11:0] be,
                                       input logic [26:0] mant);
      logic signed [11:0] d;
      logic [7:0]         n;
      logic [26:0]        m2;
      logic [7:0]         e;
      logic               inc;
      logic [30:0]        mag;
      d = 12'sd1 - be;
      if (be >= 12'sd1) n = 8'd0;
      else if (d > 12'sd27) n = 8'd27;
      else n = d[7:0];
      m2 = fp_shr_sticky(mant, n);
      e = (be >= 12'sd1) ? be[7:0] : 8'd0;
      inc = m2[2] & (m2[3] | m2[1] | m2[0]);
      mag = {e, m2[25:3]} + 31'(inc);
      if (be > 12'sd254 || mag[30:23] == 8'hFF) fp_round = {sign, 8'hFF, 23'd0};
      else fp_round = {sign, mag};
   endfunction

endpackage
`default_nettype wire

// ===== src/ljpf_fmul.sv =====
// Two-stage IEEE single multiplier, round to nearest even.
// Depends on ljpf_pkg.
`default_nettype none
module ljpf_fmul import ljpf_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   in_valid,
   input  wire fp_type a,
   input  wire fp_type b,
   output logic        out_valid,
   output fp_type      result
);

   logic        v1_ff, v2_ff;
   logic        spec_ff, spec_in;
   fp_type      spec_val_ff, spec_val_in;
   logic        sign_ff;
   logic [8:0]  exp_ff;
   logic [47:0] prod_ff;
   fp_type      res_ff, res_in;

   logic       sign_in;
   logic [7:0] ea, eb;
   logic       a_zero, b_zero;
   logic [5:0]  lz;
   logic [47:0] norm;
   logic signed [11:0] be;

   assign sign_in = a[31] ^ b[31];
   assign ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
   assign eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
   assign a_zero = (a[30:0] == 31'd0);
   assign b_zero = (b[30:0] == 31'd0);

   always_comb begin
      spec_in = 1'b1;
      spec_val_in = {sign_in, 31'd0};
      if (fp_is_nan(a)) spec_val_in = a | FP_QUIET_BIT;
      else if (fp_is_nan(b)) spec_val_in = b | FP_QUIET_BIT;
      else if ((fp_is_inf(a) && b_zero) || (a_zero && fp_is_inf(b)))
         spec_val_in = FP_DEFAULT_NAN;
      else if (fp_is_inf(a) || fp_is_inf(b)) spec_val_in = {sign_in, 8'hFF, 23'd0};
      else if (a_zero || b_zero) spec_val_in = {sign_in, 31'd0};
      else spec_in = 1'b0;
   end

   // biased exponent of the normalised product: ea + eb - 127 + 1 - lz
   assign lz = fp_lzc48(prod_ff);
   assign norm = prod_ff << lz;
   assign be = $signed({3'd0, exp_ff}) - 12'sd126 - $signed({6'd0, lz});
   assign res_in = spec_ff ? spec_val_ff
                           : fp_round(sign_ff, be, {norm[47:22], |norm[21:0]});

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      spec_ff <= spec_in;
      spec_val_ff <= spec_val_in;
      sign_ff <= sign_in;
      exp_ff <= {1'b0, ea} + {1'b0, eb};
      prod_ff <= {(a[30:23] != 8'd0), a[22:0]} * {(b[30:23] != 8'd0), b[22:0]};
      res_ff <= res_in;
   end

   assign out_valid = v2_ff;
   assign result = res_ff;

endmodule
`default_nettype wire

// ===== src/ljpf_fadd.sv =====
// Two-stage IEEE single adder and subtracter, round to nearest even.
// Depends on ljpf_pkg.
`default_nettype none
module ljpf_fadd import ljpf_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   in_valid,
   input  wire logic   sub,
   input  wire fp_type a,
   input  wire fp_type b,
   output logic        out_valid,
   output fp_type      result
);

   logic        v1_ff, v2_ff;
   logic        spec_ff, spec_in;
   fp_type      spec_val_ff, spec_val_in;
   logic        sign_ff, sign_in;
   logic [7:0]  exp_ff;
   logic [27:0] sum_ff, sum_in;
   fp_type      res_ff, res_in;

   fp_type      bb, big, sml;
   logic [7:0]  eb_big, eb_sml;
   logic [26:0] m_big, m_sml;
   logic [5:0]  lz;
   logic [26:0] norm;

   assign bb = {b[31] ^ sub, b[30:0]};

   always_comb begin
      spec_in = 1'b1;
      spec_val_in = a;
      if (fp_is_nan(a)) spec_val_in = a | FP_QUIET_BIT;
      else if (fp_is_nan(b)) spec_val_in = b | FP_QUIET_BIT;
      else if (fp_is_inf(a) && fp_is_inf(bb) && (a[31] != bb[31]))
         spec_val_in = FP_DEFAULT_NAN;
      else if (fp_is_inf(a)) spec_val_in = a;
      else if (fp_is_inf(bb)) spec_val_in = bb;
      else spec_in = 1'b0;
   end

   always_comb begin
      if (bb[30:0] > a[30:0]) begin
         big = bb;
         sml = a;
      end else begin
         big = a;
         sml = bb;
      end
      eb_big = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
      eb_sml = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
      m_big = {(big[30:23] != 8'd0), big[22:0], 3'd0};
      m_sml = fp_shr_sticky({(sml[30:23] != 8'd0), sml[22:0], 3'd0}, eb_big - eb_sml);
      if (big[31] == sml[31]) sum_in = {1'b0, m_big} + {1'b0, m_sml};
      else sum_in = {1'b0, m_big} - {1'b0, m_sml};
      // exact zero takes plus unless both addends, b after the sub sign flip, are minus
      sign_in = (sum_in == 28'd0) ? (a[31] & bb[31]) : big[31];
   end

   assign lz = fp_lzc48({sum_ff[26:0], 21'd0});
   assign norm = sum_ff[26:0] << lz;

   always_comb begin
      if (spec_ff) res_in = spec_val_ff;
      else if (sum_ff == 28'd0) res_in = {sign_ff, 31'd0};
      else if (sum_ff[27])
         res_in = fp_round(sign_ff, $signed({4'd0, exp_ff}) + 12'sd1,
                           {sum_ff[27:2], |sum_ff[1:0]});
      else res_in = fp_round(sign_ff, $signed({4'd0, exp_ff}) - $signed({6'd0, lz}), norm);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      spec_ff <= spec_in;
      spec_val_ff <= spec_val_in;
      sign_ff <= sign_in;
      exp_ff <= eb_big;
      sum_ff <= sum_in;
      res_ff <= res_in;
   end

   assign out_valid = v2_ff;
   assign result = res_ff;

endmodule
`default_nettype wire

// ===== src/ljpf_frcp.sv =====
// Iterative IEEE single reciprocal 1/d, one quotient bit per cycle.
// Depends on ljpf_pkg.
`default_nettype none
module ljpf_frcp import ljpf_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   start,
   input  wire fp_type d,
   output logic        done,
   output fp_type      result
);

   localparam logic [4:0] LAST_BIT = 5'd28;

   logic        busy_ff, done_ff;
   logic [4:0]  cnt_ff;
   logic [24:0] rem_ff, rem_in;
   logic [27:0] quo_ff;
   logic [23:0] dn_ff;
   logic signed [11:0] edn_ff;
   logic        sign_ff;
   fp_type      res_ff;

   logic [23:0] m;
   logic [5:0]  lz;
   logic        ge, st;
   fp_type      spec_val;
   fp_type      final_val;

   assign m = {(d[30:23] != 8'd0), d[22:0]};
   assign lz = fp_lzc48({m, 24'd0});
   assign ge = rem_ff >= {1'b0, dn_ff};
   assign rem_in = ge ? ((rem_ff - {1'b0, dn_ff}) << 1) : (rem_ff << 1);
   assign st = (rem_ff != 25'd0);

   always_comb begin
      if (fp_is_nan(d)) spec_val = d | FP_QUIET_BIT;
      else if (fp_is_inf(d)) spec_val = {d[31], 31'd0};
      else spec_val = {d[31], 8'hFF, 23'd0};
      if (quo_ff[27])
         final_val = fp_round(sign_ff, 12'sd254 - edn_ff, {quo_ff[27:2], |quo_ff[1:0] | st});
      else
         final_val = fp_round(sign_ff, 12'sd253 - edn_ff, {quo_ff[26:1], quo_ff[0] | st});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            if (fp_is_nan(d) || (d[30:23] == 8'hFF) || (d[30:0] == 31'd0)) begin
               res_ff <= spec_val;
               done_ff <= 1'b1;
            end else begin
               busy_ff <= 1'b1;
            end
         end else if (busy_ff && cnt_ff == LAST_BIT) begin
            res_ff <= final_val;
            done_ff <= 1'b1;
            busy_ff <= 1'b0;
         end
      end
      if (start) begin
         cnt_ff <= 5'd0;
         rem_ff <= 25'h080_0000;
         quo_ff <= 28'd0;
         dn_ff <= m << lz;
         edn_ff <= $signed({4'd0, (d[30:23] == 8'd0) ? 8'd1 : d[30:23]})
                   - $signed({6'd0, lz});
         sign_ff <= d[31];
      end else if (busy_ff && cnt_ff != LAST_BIT) begin
         cnt_ff <= cnt_ff + 5'd1;
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[26:0], ge};
      end
   end

   assign done = done_ff;
   assign result = res_ff;

endmodule
`default_nettype wire

// ===== src/lj_pair_force_accumulator.sv =====
// Lennard-Jones 12-6 pair force accumulator: position, force and coefficient
// memories with a sequencer over shared float units. Depends on ljpf_pkg,
// ljpf_fmul, ljpf_fadd and ljpf_frcp.
//
//   channel   ports                       direction  handshake
//   req       req_command .. req_value_z  in         req_valid / req_ready
//   rsp       rsp_force_x .. rsp_status   out        rsp_valid / rsp_ready
//   csr       csr_wdata (type_base)       in         csr_we, no wait
//
// Position and table writes go straight to S_RESP; a force read goes via S_RDF.
// Pair: S_RDB and S_CAP, then its 25 add and multiply steps on the two-stage
// adder and multiplier and the reciprocal step, each issued after the last
// result returns; a zero distance ends it after the squared distance.
// After reset a clearing pass zeroes the force memory while req_ready stays low.
// A new item is taken while a result waits; the next result holds until rsp drains.
`default_nettype none
module lj_pair_force_accumulator import ljpf_pkg::*; #(
   parameter int ATOM_COUNT = 4096,
   parameter int TYPE_COUNT = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_command,
   input  wire logic [11:0] req_atom_a,
   input  wire logic [11:0] req_atom_b,
   input  wire logic [7:0]  req_pair_type,
   input  wire logic [31:0] req_value_x,
   input  wire logic [31:0] req_value_y,
   input  wire logic [31:0] req_value_z,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_force_x,
   output logic [31:0]      rsp_force_y,
   output logic [31:0]      rsp_force_z,
   output logic [1:0]       rsp_status,
   input  wire logic        csr_we,
   input  wire logic [7:0]  csr_wdata
);

   localparam int AW = (ATOM_COUNT > 1) ? $clog2(ATOM_COUNT) : 1;
   localparam int TW = (TYPE_COUNT > 1) ? $clog2(TYPE_COUNT) : 1;
   localparam logic [AW-1:0] LAST_ATOM = AW'(ATOM_COUNT - 1);

   localparam logic [3:0] S_CLR   = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_RDF   = 4'd2;
   localparam logic [3:0] S_RDB   = 4'd3;
   localparam logic [3:0] S_CAP   = 4'd4;
   localparam logic [3:0] S_ISSUE = 4'd5;
   localparam logic [3:0] S_WAIT  = 4'd6;
   localparam logic [3:0] S_WBA   = 4'd7;
   localparam logic [3:0] S_WBB   = 4'd8;
   localparam logic [3:0] S_RESP  = 4'd9;

   localparam logic [1:0] U_ADD = 2'd0;
   localparam logic [1:0] U_MUL = 2'd1;
   localparam logic [1:0] U_RCP = 2'd2;

   localparam logic [4:0] STEP_RSQ  = 5'd7;
   localparam logic [4:0] STEP_LAST = 5'd25;

   logic [3:0]    state_ff, state_in;
   logic [4:0]    step_ff;
   logic [AW-1:0] clr_cnt_ff;
   logic [7:0]    type_base_ff;
   logic [AW-1:0] a_ff, b_ff;

   // memories and their registered read data
   logic [95:0] pos_mem [ATOM_COUNT];
   logic [95:0] frc_mem [ATOM_COUNT];
   logic [63:0] coef_mem [TYPE_COUNT];
   logic [95:0] pos_rd_ff, frc_rd_ff;
   logic [63:0] coef_rd_ff;

   fp_type pax_ff, pay_ff, paz_ff, pbx_ff, pby_ff, pbz_ff;
   fp_type fax_ff, fay_ff, faz_ff, fbx_ff, fby_ff, fbz_ff;
   fp_type c6_ff, c12_ff;
   fp_type dx_ff, dy_ff, dz_ff, sx_ff, sy_ff, sz_ff, rsq_ff, r2_ff, r6_ff;
   fp_type p_ff, q_ff, inner_ff, outer_ff, f_ff, fx_ff, fy_ff, fz_ff;

   fp_type     res_fx_ff, res_fy_ff, res_fz_ff;
   logic [1:0] res_st_ff;
   logic       rsp_valid_ff;
   fp_type     rsp_fx_ff, rsp_fy_ff, rsp_fz_ff;
   logic [1:0] rsp_st_ff;

   logic          accept;
   logic [31:0]   a_ext, b_ext;
   logic          a_ok, b_ok;
   logic [8:0]    tdiff;
   logic          t_ok, tw_ok;
   logic [AW-1:0] a_idx, b_idx;
   logic [TW-1:0] t_idx, tw_idx;

   logic          pos_we, frc_we, coef_we;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [95:0]   frc_wdata;

   logic [1:0] op_unit;
   logic       op_sub;
   fp_type     op_a, op_b;
   logic       mul_go, add_go, rcp_go;
   logic       mul_ov, add_ov, rcp_done;
   fp_type     mul_res, add_res, rcp_res;
   logic       unit_done;
   fp_type     unit_res;
   logic       resp_load;

   assign accept = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);

   assign a_ext = 32'(req_atom_a);
   assign b_ext = 32'(req_atom_b);
   assign a_ok = a_ext < 32'(ATOM_COUNT);
   assign b_ok = b_ext < 32'(ATOM_COUNT);
   assign a_idx = a_ext[AW-1:0];
   assign b_idx = b_ext[AW-1:0];
   assign tdiff = {1'b0, req_pair_type} - {1'b0, type_base_ff};
   assign t_ok = !tdiff[8] && (32'(tdiff[7:0]) < 32'(TYPE_COUNT));
   assign t_idx = TW'(32'(tdiff[7:0]));
   assign tw_ok = 32'(req_pair_type) < 32'(TYPE_COUNT);
   assign tw_idx = TW'(32'(req_pair_type));

   // memory ports
   assign pos_we = accept && req_command == CMD_WRITE_POS && a_ok;
   assign coef_we = accept && req_command == CMD_WRITE_COEF && tw_ok;
   assign frc_we = pos_we || state_ff == S_CLR || state_ff == S_WBA || state_ff == S_WBB;

   always_comb begin
      case (state_ff)
         S_CLR:   wr_addr = clr_cnt_ff;
         S_WBA:   wr_addr = a_ff;
         S_WBB:   wr_addr = b_ff;
         default: wr_addr = a_idx;
      endcase
      case (state_ff)
         S_WBA:   frc_wdata = {faz_ff, fay_ff, fax_ff};
         S_WBB:   frc_wdata = {fbz_ff, fby_ff, fbx_ff};
         default: frc_wdata = 96'd0;
      endcase
   end

   assign rd_addr = (state_ff == S_RDB) ? b_ff : a_idx;

   always_ff @(posedge clock) begin
      if (pos_we) pos_mem[wr_addr] <= {req_value_z, req_value_y, req_value_x};
      pos_rd_ff <= pos_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (frc_we) frc_mem[wr_addr] <= frc_wdata;
      frc_rd_ff <= frc_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (coef_we) coef_mem[tw_idx] <= {req_value_y, req_value_x};
      coef_rd_ff <= coef_mem[t_idx];
   end

   // pair program: one float operation per step
   always_comb begin
      op_unit = U_ADD;
      op_sub = 1'b0;
      op_a = 32'd0;
      op_b = 32'd0;
      case (step_ff)
         5'd0: begin op_sub = 1'b1; op_a = pax_ff; op_b = pbx_ff; end
         5'd1: begin op_sub = 1'b1; op_a = pay_ff; op_b = pby_ff; end
         5'd2: begin op_sub = 1'b1; op_a = paz_ff; op_b = pbz_ff; end
         5'd3: begin op_unit = U_MUL; op_a = dx_ff; op_b = dx_ff; end
         5'd4: begin op_unit = U_MUL; op_a = dy_ff; op_b = dy_ff; end
         5'd5: begin op_unit = U_MUL; op_a = dz_ff; op_b = dz_ff; end
         5'd6: begin op_a = sx_ff; op_b = sy_ff; end
         5'd7: begin op_a = rsq_ff; op_b = sz_ff; end
         5'd8: begin op_unit = U_RCP; op_a = rsq_ff; end
         5'd9: begin op_unit = U_MUL; op_a = r2_ff; op_b = r2_ff; end
         5'd10: begin op_unit = U_MUL; op_a = r6_ff; op_b = r2_ff; end
         5'd11: begin op_unit = U_MUL; op_a = FP_TWELVE; op_b = c12_ff; end
         5'd12: begin op_unit = U_MUL; op_a = p_ff; op_b = r6_ff; end
         5'd13: begin op_unit = U_MUL; op_a = FP_SIX; op_b = c6_ff; end
         5'd14: begin op_sub = 1'b1; op_a = p_ff; op_b = q_ff; end
         5'd15: begin op_unit = U_MUL; op_a = r2_ff; op_b = r6_ff; end
         5'd16: begin op_unit = U_MUL; op_a = outer_ff; op_b = inner_ff; end
         5'd17: begin op_unit = U_MUL; op_a = f_ff; op_b = dx_ff; end
         5'd18: begin op_unit = U_MUL; op_a = f_ff; op_b = dy_ff; end
         5'd19: begin op_unit = U_MUL; op_a = f_ff; op_b = dz_ff; end
         5'd20: begin op_a = fax_ff; op_b = fx_ff; end
         5'd21: begin op_a = fay_ff; op_b = fy_ff; end
         5'd22: begin op_a = faz_ff; op_b = fz_ff; end
         5'd23: begin op_sub = 1'b1; op_a = fbx_ff; op_b = fx_ff; end
         5'd24: begin op_sub = 1'b1; op_a = fby_ff; op_b = fy_ff; end
         5'd25: begin op_sub = 1'b1; op_a = fbz_ff; op_b = fz_ff; end
         default: begin op_unit = U_ADD; end
      endcase
   end

   assign mul_go = (state_ff == S_ISSUE) && op_unit == U_MUL;
   assign add_go = (state_ff == S_ISSUE) && op_unit == U_ADD;
   assign rcp_go = (state_ff == S_ISSUE) && op_unit == U_RCP;

   ljpf_fmul u_fmul (
      .clock(clock), .reset(reset), .in_valid(mul_go), .a(op_a), .b(op_b),
      .out_valid(mul_ov), .result(mul_res)
   );

   ljpf_fadd u_fadd (
      .clock(clock), .reset(reset), .in_valid(add_go), .sub(op_sub), .a(op_a), .b(op_b),
      .out_valid(add_ov), .result(add_res)
   );

   ljpf_frcp u_frcp (
      .clock(clock), .reset(reset), .start(rcp_go), .d(op_a),
      .done(rcp_done), .result(rcp_res)
   );

   always_comb begin
      case (op_unit)
         U_MUL:   begin unit_done = mul_ov;   unit_res = mul_res; end
         U_RCP:   begin unit_done = rcp_done; unit_res = rcp_res; end
         default: begin unit_done = add_ov;   unit_res = add_res; end
      endcase
   end

   assign resp_load = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLR: if (clr_cnt_ff == LAST_ATOM) state_in = S_IDLE;
         S_IDLE: begin
            if (accept) begin
               if (req_command == CMD_READ_FORCE && a_ok) state_in = S_RDF;
               else if (req_command == CMD_PAIR && t_ok && a_ok && b_ok) state_in = S_RDB;
               else state_in = S_RESP;
            end
         end
         S_RDF:   state_in = S_RESP;
         S_RDB:   state_in = S_CAP;
         S_CAP:   state_in = S_ISSUE;
         S_ISSUE: state_in = S_WAIT;
         S_WAIT: begin
            if (unit_done) begin
               if (step_ff == STEP_RSQ && unit_res[30:0] == 31'd0) state_in = S_RESP;
               else if (step_ff == STEP_LAST) state_in = S_WBA;
               else state_in = S_ISSUE;
            end
         end
         S_WBA:  state_in = S_WBB;
         S_WBB:  state_in = S_RESP;
         S_RESP: if (resp_load) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         clr_cnt_ff <= '0;
         type_base_ff <= 8'd0;
         rsp_valid_ff <= 1'b0;
         step_ff <= 5'd0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLR) clr_cnt_ff <= clr_cnt_ff + AW'(1);
         if (csr_we) type_base_ff <= csr_wdata;
         if (resp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         if (state_ff == S_CAP) step_ff <= 5'd0;
         else if (state_ff == S_WAIT && unit_done) step_ff <= step_ff + 5'd1;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         a_ff <= a_idx;
         b_ff <= b_idx;
         res_fx_ff <= 32'd0;
         res_fy_ff <= 32'd0;
         res_fz_ff <= 32'd0;
         res_st_ff <= ((req_command == CMD_PAIR && !(t_ok && a_ok && b_ok))
                       || (req_command == CMD_WRITE_COEF && !tw_ok)) ? ST_RANGE : ST_OK;
      end
      if (state_ff == S_RDF) begin
         res_fx_ff <= frc_rd_ff[31:0];
         res_fy_ff <= frc_rd_ff[63:32];
         res_fz_ff <= frc_rd_ff[95:64];
      end
      if (state_ff == S_RDB) begin
         {paz_ff, pay_ff, pax_ff} <= pos_rd_ff;
         {faz_ff, fay_ff, fax_ff} <= frc_rd_ff;
         {c12_ff, c6_ff} <= coef_rd_ff;
      end
      if (state_ff == S_CAP) begin
         {pbz_ff, pby_ff, pbx_ff} <= pos_rd_ff;
         {fbz_ff, fby_ff, fbx_ff} <= frc_rd_ff;
      end
      if (state_ff == S_WAIT && unit_done) begin
         if (step_ff == STEP_RSQ && unit_res[30:0] == 31'd0) res_st_ff <= ST_ZERO;
         case (step_ff)
            5'd0:  dx_ff <= unit_res;
            5'd1:  dy_ff <= unit_res;
            5'd2:  dz_ff <= unit_res;
            5'd3:  sx_ff <= unit_res;
            5'd4:  sy_ff <= unit_res;
            5'd5:  sz_ff <= unit_res;
            5'd6:  rsq_ff <= unit_res;
            5'd7:  rsq_ff <= unit_res;
            5'd8:  r2_ff <= unit_res;
            5'd9:  r6_ff <= unit_res;
            5'd10: r6_ff <= unit_res;
            5'd11: p_ff <= unit_res;
            5'd12: p_ff <= unit_res;
            5'd13: q_ff <= unit_res;
            5'd14: inner_ff <= unit_res;
            5'd15: outer_ff <= unit_res;
            5'd16: f_ff <= unit_res;
            5'd17: fx_ff <= unit_res;
            5'd18: fy_ff <= unit_res;
            5'd19: fz_ff <= unit_res;
            5'd20: fax_ff <= unit_res;
            5'd21: fay_ff <= unit_res;
            5'd22: faz_ff <= unit_res;
            5'd23: fbx_ff <= unit_res;
            5'd24: fby_ff <= unit_res;
            5'd25: fbz_ff <= unit_res;
            default: f_ff <= f_ff;
         endcase
      end
      if (resp_load) begin
         rsp_fx_ff <= res_fx_ff;
         rsp_fy_ff <= res_fy_ff;
         rsp_fz_ff <= res_fz_ff;
         rsp_st_ff <= res_st_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_force_x = rsp_fx_ff;
   assign rsp_force_y = rsp_fy_ff;
   assign rsp_force_z = rsp_fz_ff;
   assign rsp_status = rsp_st_ff;

`ifndef SYNTHESIS
   // the second write-back always follows the first
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WBB) |-> $past(state_ff == S_WBA))
      else $error("pair write-back out of order");

   assert property (@(posedge clock) disable iff (reset)
      $onehot0({mul_go, add_go, rcp_go}))
      else $error("more than one float unit started");

   assert property (@(posedge clock) disable iff (reset)
      (mul_ov || add_ov || rcp_done) |-> (state_ff == S_WAIT))
      else $error("float result outside the wait state");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLR) |-> !req_ready)
      else $error("request taken during force clearing");
`endif

endmodule
`default_nettype wire

// ===== verif/lj_pair_force_checker.sv =====
// Scoreboard for the pair force accumulator: tracks req, csr and rsp transfers,
// keeps its own copy of positions, forces and coefficients, and compares replies.
// Depends on ljpf_pkg for command and status codes.
`timescale 1ns / 100ps
module lj_pair_force_checker import ljpf_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic [1:0]  req_command,
   input  wire logic [11:0] req_atom_a,
   input  wire logic [11:0] req_atom_b,
   input  wire logic [7:0]  req_pair_type,
   input  wire logic [31:0] req_value_x,
   input  wire logic [31:0] req_value_y,
   input  wire logic [31:0] req_value_z,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [31:0] rsp_force_x,
   input  wire logic [31:0] rsp_force_y,
   input  wire logic [31:0] rsp_force_z,
   input  wire logic [1:0]  rsp_status,
   input  wire logic        csr_we,
   input  wire logic [7:0]  csr_wdata,
   output int               fail_count,
   output int               pending
);

   localparam int NUM_ATOMS = 4096;
   localparam int NUM_TYPES = 64;
   localparam logic [31:0] QNAN_DEFAULT = 32'hFFC0_0000;
   localparam logic [31:0] QUIET_MASK   = 32'h0040_0000;

   typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL, OP_DIV} fop_e;

   logic [31:0] pos_x [NUM_ATOMS];
   logic [31:0] pos_y [NUM_ATOMS];
   logic [31:0] pos_z [NUM_ATOMS];
   logic [31:0] acc_x [NUM_ATOMS];
   logic [31:0] acc_y [NUM_ATOMS];
   logic [31:0] acc_z [NUM_ATOMS];
   logic [31:0] c6_tab [NUM_TYPES];
   logic [31:0] c12_tab [NUM_TYPES];
   logic [7:0]  type_base;
   logic [97:0] replies_q [$];

   initial begin
      for (int i = 0; i < NUM_ATOMS; i++) begin
         pos_x[i] = '0; pos_y[i] = '0; pos_z[i] = '0;
         acc_x[i] = '0; acc_y[i] = '0; acc_z[i] = '0;
      end
      for (int i = 0; i < NUM_TYPES; i++) begin
         c6_tab[i] = '0; c12_tab[i] = '0;
      end
      type_base = '0;
      fail_count = 0;
      pending = 0;
   end

   function automatic logic is_nan(input logic [31:0] v);
      return v[30:23] == 8'hFF && v[22:0] != 0;
   endfunction

   function automatic logic is_inf(input logic [31:0] v);
      return v[30:23] == 8'hFF && v[22:0] == 0;
   endfunction

   function automatic logic is_zero(input logic [31:0] v);
      return v[30:0] == 0;
   endfunction

   // exact single to double bit conversion
   function automatic logic [63:0] widen(input logic [31:0] v);
      logic [63:0] t;
      int p;
      if (v[30:23] == 8'hFF) return {v[31], 11'h7FF, v[22:0], 29'd0};
      if (v[30:23] != 0) return {v[31], 11'(v[30:23] + 896), v[22:0], 29'd0};
      if (v[22:0] == 0) return {v[31], 63'd0};
      p = 22;
      while (!v[p]) p--;
      t = 64'(v[22:0]) << (52 - p);
      return {v[31], 11'(p + 874), t[51:0]};
   endfunction

   // double to single, round to nearest even, subnormals kept
   function automatic logic [31:0] narrow(input logic [63:0] d);
      int ue, sh, exp_base;
      logic [63:0] m, kept, mag;
      logic guard, sticky;
      if (d[62:52] == 11'h7FF) return {d[63], 8'hFF, 23'd0};
      if (d[62:52] == 0) return {d[63], 31'd0};
      ue = int'(d[62:52]) - 1023;
      if (ue > 127) return {d[63], 8'hFF, 23'd0};
      m = {11'd0, 1'b1, d[51:0]};
      if (ue >= -126) begin
         sh = 29;
         exp_base = ue + 126;
      end else begin
         sh = 29 - 126 - ue;
         exp_base = 0;
      end
      if (sh >= 54) return {d[63], 31'd0};
      kept = m >> sh;
      guard = m[sh-1];
      sticky = (m & ((64'd1 << (sh - 1)) - 64'd1)) != 0;
      if (guard && (sticky || kept[0])) kept = kept + 1;
      mag = (64'(exp_base) << 23) + kept;
      if (mag >= 64'h7F80_0000) return {d[63], 8'hFF, 23'd0};
      return {d[63], mag[30:0]};
   endfunction

   // one single-precision operation; double holds the exact or safely rounded value
   function automatic logic [31:0] fop(input fop_e op, input logic [31:0] a,
                                       input logic [31:0] b);
      real x, y, r;
      if (is_nan(a)) return a | QUIET_MASK;
      if (is_nan(b)) return b | QUIET_MASK;
      x = $bitstoreal(widen(a));
      y = $bitstoreal(widen(b));
      case (op)
         OP_ADD: begin
            if (is_inf(a) && is_inf(b) && a[31] != b[31]) return QNAN_DEFAULT;
            r = x + y;
         end
         OP_SUB: begin
            if (is_inf(a) && is_inf(b) && a[31] == b[31]) return QNAN_DEFAULT;
            r = x - y;
         end
         OP_MUL: begin
            if ((is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b))) return QNAN_DEFAULT;
            r = x * y;
         end
         default: begin
            if ((is_zero(a) && is_zero(b)) || (is_inf(a) && is_inf(b))) return QNAN_DEFAULT;
            if (is_zero(b)) return {a[31] ^ b[31], 8'hFF, 23'd0};
            r = x / y;
         end
      endcase
      return narrow($realtobits(r));
   endfunction

   // Lennard-Jones pair update in the block's operation order; returns status
   function automatic logic [1:0] apply_pair(input logic [11:0] ia, input logic [11:0] ib,
                                             input logic [7:0] ptype);
      logic [31:0] dx, dy, dz, rsq, r2inv, r6inv, p, q, inner, outer, f, fx, fy, fz;
      logic [7:0] t;
      if (ptype < type_base || ptype - type_base >= NUM_TYPES) return ST_RANGE;
      t = ptype - type_base;
      dx = fop(OP_SUB, pos_x[ia], pos_x[ib]);
      dy = fop(OP_SUB, pos_y[ia], pos_y[ib]);
      dz = fop(OP_SUB, pos_z[ia], pos_z[ib]);
      rsq = fop(OP_ADD, fop(OP_MUL, dx, dx), fop(OP_MUL, dy, dy));
      rsq = fop(OP_ADD, rsq, fop(OP_MUL, dz, dz));
      if (is_zero(rsq)) return ST_ZERO;
      r2inv = fop(OP_DIV, 32'h3F80_0000, rsq);
      r6inv = fop(OP_MUL, fop(OP_MUL, r2inv, r2inv), r2inv);
      p = fop(OP_MUL, fop(OP_MUL, 32'h4140_0000, c12_tab[t]), r6inv);
      q = fop(OP_MUL, 32'h40C0_0000, c6_tab[t]);
      inner = fop(OP_SUB, p, q);
      outer = fop(OP_MUL, r2inv, r6inv);
      f = fop(OP_MUL, outer, inner);
      fx = fop(OP_MUL, f, dx);
      fy = fop(OP_MUL, f, dy);
      fz = fop(OP_MUL, f, dz);
      acc_x[ia] = fop(OP_ADD, acc_x[ia], fx);
      acc_y[ia] = fop(OP_ADD, acc_y[ia], fy);
      acc_z[ia] = fop(OP_ADD, acc_z[ia], fz);
      acc_x[ib] = fop(OP_SUB, acc_x[ib], fx);
      acc_y[ib] = fop(OP_SUB, acc_y[ib], fy);
      acc_z[ib] = fop(OP_SUB, acc_z[ib], fz);
      return ST_OK;
   endfunction

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      logic [31:0] fx, fy, fz;
      logic [1:0]  st;
      logic [97:0] want;
      if (reset) begin
         type_base = '0;
         replies_q.delete();
      end else begin
         if (csr_we) type_base = csr_wdata;
         if (req_valid && req_ready) begin
            fx = '0; fy = '0; fz = '0; st = ST_OK;
            case (req_command)
               CMD_WRITE_POS: begin
                  pos_x[req_atom_a] = req_value_x;
                  pos_y[req_atom_a] = req_value_y;
                  pos_z[req_atom_a] = req_value_z;
                  acc_x[req_atom_a] = '0;
                  acc_y[req_atom_a] = '0;
                  acc_z[req_atom_a] = '0;
               end
               CMD_PAIR: st = apply_pair(req_atom_a, req_atom_b, req_pair_type);
               CMD_READ_FORCE: begin
                  fx = acc_x[req_atom_a];
                  fy = acc_y[req_atom_a];
                  fz = acc_z[req_atom_a];
               end
               default: begin
                  if (req_pair_type < NUM_TYPES) begin
                     c6_tab[req_pair_type] = req_value_x;
                     c12_tab[req_pair_type] = req_value_y;
                  end else begin
                     st = ST_RANGE;
                  end
               end
            endcase
            replies_q.push_back({fx, fy, fz, st});
         end
         if (rsp_valid && rsp_ready) begin
            if (replies_q.size() == 0) begin
               $display("%0t: reply with none outstanding, got %h %h %h status %0d",
                        $time, rsp_force_x, rsp_force_y, rsp_force_z, rsp_status);
               fail_count++;
            end else begin
               want = replies_q.pop_front();
               compare_field("force_x", want[97:66], rsp_force_x);
               compare_field("force_y", want[65:34], rsp_force_y);
               compare_field("force_z", want[33:2], rsp_force_z);
               compare_field("status", 32'(want[1:0]), 32'(rsp_status));
            end
         end
      end
      pending = replies_q.size();
   end

endmodule

// ===== verif/tb_lj_pair_force_accumulator.sv =====
// Top of the pair force accumulator testbench: clock, reset, stimulus and verdict.
// Depends on ljpf_pkg, the block and lj_pair_force_checker.
`timescale 1ns / 100ps
module tb_lj_pair_force_accumulator;
   import ljpf_pkg::*;

   localparam int STALL_LIMIT = 40000;
   localparam int DRAIN_WAIT  = 150;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_command = CMD_READ_FORCE;
   logic [11:0] req_atom_a = '0;
   logic [11:0] req_atom_b = '0;
   logic [7:0]  req_pair_type = '0;
   logic [31:0] req_value_x = '0;
   logic [31:0] req_value_y = '0;
   logic [31:0] req_value_z = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_force_x, rsp_force_y, rsp_force_z;
   logic [1:0]  rsp_status;
   logic        csr_we = 1'b0;
   logic [7:0]  csr_wdata = '0;

   int fail_count, pending;
   int send_idle = 0;
   int rsp_stall = 0;
   int quiet_cycles = 0;
   int n_sent = 0, n_pairs = 0, n_reads = 0;
   logic [7:0] cur_base = '0;
   bit placed [4096];
   bit coef_set [64];

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   lj_pair_force_accumulator dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_command(req_command), .req_atom_a(req_atom_a), .req_atom_b(req_atom_b),
      .req_pair_type(req_pair_type), .req_value_x(req_value_x),
      .req_value_y(req_value_y), .req_value_z(req_value_z),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_force_x(rsp_force_x), .rsp_force_y(rsp_force_y),
      .rsp_force_z(rsp_force_z), .rsp_status(rsp_status),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   lj_pair_force_checker scoreboard (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_command(req_command), .req_atom_a(req_atom_a), .req_atom_b(req_atom_b),
      .req_pair_type(req_pair_type), .req_value_x(req_value_x),
      .req_value_y(req_value_y), .req_value_z(req_value_z),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_force_x(rsp_force_x), .rsp_force_y(rsp_force_y),
      .rsp_force_z(rsp_force_z), .rsp_status(rsp_status),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending)
   );

   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= rsp_stall);

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", quiet_cycles);
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic put(input logic [1:0] cmd, input logic [11:0] a, input logic [11:0] b,
                      input logic [7:0] t, input logic [31:0] x, input logic [31:0] y,
                      input logic [31:0] z);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_atom_a <= a;
      req_atom_b <= b;
      req_pair_type <= t;
      req_value_x <= x;
      req_value_y <= y;
      req_value_z <= z;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      n_sent++;
      if (cmd == CMD_WRITE_POS) placed[a] = 1'b1;
      if (cmd == CMD_WRITE_COEF && t < 64) coef_set[t] = 1'b1;
      if (cmd == CMD_PAIR) n_pairs++;
      if (cmd == CMD_READ_FORCE) n_reads++;
   endtask

   function automatic logic [31:0] pos_value();
      if ($urandom_range(99) < 8) return $urandom;
      return {1'($urandom), 8'($urandom_range(124, 131)), 23'($urandom)};
   endfunction

   function automatic logic [31:0] coef_value();
      if ($urandom_range(99) < 8) return $urandom;
      if ($urandom_range(99) < 3) return 32'h0;
      return {1'($urandom), 8'($urandom_range(118, 134)), 23'($urandom)};
   endfunction

   function automatic logic [11:0] pick_atom();
      int r;
      r = $urandom_range(99);
      if (r < 85) return 12'($urandom_range(47));
      if (r < 95) return 12'($urandom);
      return (r < 97) ? 12'd4095 : 12'd0;
   endfunction

   task automatic random_item();
      int sel, idx;
      logic [11:0] a, b;
      logic [7:0] t;
      sel = $urandom_range(99);
      a = pick_atom();
      b = ($urandom_range(99) < 3) ? a : pick_atom();
      if (sel < 12 || !placed[a]) begin
         put(CMD_WRITE_POS, a, 12'($urandom), 8'($urandom), pos_value(), pos_value(),
             pos_value());
      end else if (sel < 22) begin
         t = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(63));
         put(CMD_WRITE_COEF, 12'($urandom), 12'($urandom), t, coef_value(), coef_value(),
             $urandom);
      end else if (sel < 40) begin
         put(CMD_READ_FORCE, ($urandom_range(9) == 0) ? 12'($urandom) : a, 12'($urandom),
             8'($urandom), $urandom, $urandom, $urandom);
      end else if (!placed[b]) begin
         put(CMD_WRITE_POS, b, 12'($urandom), 8'($urandom), pos_value(), pos_value(),
             pos_value());
      end else begin
         // mostly in-table types; now and then any raw type
         if ($urandom_range(19) == 0) t = 8'($urandom);
         else t = 8'(cur_base + $urandom_range(63));
         idx = int'(t) - int'(cur_base);
         if (idx >= 0 && idx < 64 && !coef_set[idx])
            put(CMD_WRITE_COEF, 12'($urandom), 12'($urandom), 8'(idx), coef_value(),
                coef_value(), $urandom);
         else
            put(CMD_PAIR, a, b, t, $urandom, $urandom, $urandom);
      end
   endtask

   task automatic run_phase(input logic [7:0] base, input int s_idle, input int r_stall,
                            input int count);
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= base;
      @(posedge clock);
      csr_we <= 1'b0;
      cur_base = base;
      send_idle = s_idle;
      rsp_stall = r_stall;
      repeat (count) random_item();
   endtask

   initial begin
      logic [7:0] mid_base;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // table edges and out-of-range table writes
      put(CMD_WRITE_COEF, 0, 0, 8'd0, 32'h3F80_0000, 32'h3F80_0000, 0);
      put(CMD_WRITE_COEF, 0, 0, 8'd63, 32'h7F7F_FFFF, 32'h0000_0001, 0);
      put(CMD_WRITE_COEF, 0, 0, 8'd64, 32'h3F80_0000, 32'h3F80_0000, 0);
      put(CMD_WRITE_COEF, 0, 0, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
      // end atoms, a coincident pair, non-finite coordinates, an out-of-range type and force reads
      put(CMD_WRITE_POS, 12'd0, 0, 0, 32'h0, 32'h0, 32'h0);
      put(CMD_WRITE_POS, 12'd4095, 12'hFFF, 8'hFF, 32'h3FC0_0000, 32'h3F00_0000,
          32'hC000_0000);
      put(CMD_WRITE_POS, 12'd1, 0, 0, 32'h8000_0000, 32'h0, 32'h0);
      put(CMD_WRITE_POS, 12'd2, 0, 0, 32'hFFFF_FFFF, 32'h7F80_0000, 32'h0000_0001);
      put(CMD_WRITE_POS, 12'd3, 0, 0, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000);
      put(CMD_PAIR, 12'd0, 12'd4095, 8'd0, 0, 0, 0);
      put(CMD_PAIR, 12'd4095, 12'd0, 8'd63, 0, 0, 0);
      put(CMD_PAIR, 12'd3, 12'd0, 8'd0, 0, 0, 0);
      put(CMD_PAIR, 12'd0, 12'd0, 8'd0, 0, 0, 0);
      put(CMD_PAIR, 12'd0, 12'd1, 8'd0, 0, 0, 0);
      put(CMD_PAIR, 12'd0, 12'd4095, 8'd64, 0, 0, 0);
      put(CMD_PAIR, 12'd2, 12'd0, 8'd0, 0, 0, 0);
      put(CMD_READ_FORCE, 12'd0, 0, 0, 0, 0, 0);
      put(CMD_READ_FORCE, 12'd4095, 0, 0, 0, 0, 0);
      put(CMD_READ_FORCE, 12'd2, 0, 0, 0, 0, 0);
      put(CMD_READ_FORCE, 12'd3, 0, 0, 0, 0, 0);
      put(CMD_READ_FORCE, 12'd100, 0, 0, 0, 0, 0);

      mid_base = 8'($urandom_range(1, 254));
      run_phase(8'd0, 0, 0, 235);
      run_phase(8'd255, 56, 0, 230);
      run_phase(mid_base, 0, 56, 230);
      run_phase(8'd3, 12, 12, 235);

      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("Summary: %0d requests, %0d pairs and %0d force reads, type_base 0, 255, %0d, 3",
               n_sent, n_pairs, n_reads, mid_base);
      $display("  under free-running, sender-idle, receiver-stall and mixed handshakes");
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
